// File: rtl/gcdlcm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcdlcm_pkg
// shared types and constants of the gcd / lcm block
// ----------------------------------------------------------------------------
package gcdlcm_pkg;

  localparam int CNT_W         = 6;   // prime factor count width
  localparam int FIRST_DIVISOR = 2;   // trial division starts here
  localparam int OUT_G_W       = 32;
  localparam int OUT_M_W       = 64;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// File: rtl/gcdlcm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcdlcm_div
// restoring divider, one quotient bit per cycle, shared by the count, euclid and quotient phases
// ----------------------------------------------------------------------------
module gcdlcm_div
  import gcdlcm_pkg::*;
#(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic      [W-1:0] quotient,
  output logic      [W-1:0] remainder,
  output div_stat_t         stat
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] count;
  logic [W-1:0]  dsr;
  logic [W:0]    rem_sh;
  logic [W:0]    rem_sub;
  logic          fits;

  assign rem_sh  = {remainder, quotient[W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign fits    = (rem_sh >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      stat  <= '0;
      count <= '0;
    end else begin
      // one-cycle pulse after the last quotient bit
      stat.done <= !start && stat.busy && (count == CW'(1));
      if (start) begin
        quotient  <= dividend;
        remainder <= '0;
        dsr       <= divisor;
        count     <= CW'(W);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        if (fits) begin
          remainder <= rem_sub[W-1:0];
          quotient  <= {quotient[W-2:0], 1'b1};
        end else begin
          remainder <= rem_sh[W-1:0];
          quotient  <= {quotient[W-2:0], 1'b0};
        end
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !start) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> $past(stat.busy)) else $error("done without a running division");
  a_nonzero_divisor: assert property (@(posedge clk) disable iff (rst)
    start |-> divisor != '0) else $error("division by zero requested");
`endif

endmodule
`default_nettype wire

// File: rtl/gcd_lcm_by_prime_factors.sv
`default_nettype none
// divides on the shared divider: one per trial divisor plus one per factor found in each
// operand (up to the square root of what remains), one per euclid step, and one
// for a / gcd
// one item at a time; the next beat is taken while a result waits on m_*
// synchronous reset clears the sequencer and output valid
// ----------------------------------------------------------------------------
// gcd_lcm_by_prime_factors
// factor counts by trial division, gcd and lcm through one shared divider
// ----------------------------------------------------------------------------
module gcd_lcm_by_prime_factors
  import gcdlcm_pkg::*;
#(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [63:0]  s_tdata,   // first_number, second_number
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic      [111:0] m_tdata,   // common_factor, common_multiple,
                                       // first_factor_count, second_factor_count
  output logic      [0:0]   m_tuser    // input_invalid
);

  localparam int W = OPERAND_WIDTH;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CNTA = 3'd1;
  localparam logic [2:0] ST_CNTB = 3'd2;
  localparam logic [2:0] ST_EUC  = 3'd3;
  localparam logic [2:0] ST_QUO  = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]       state;
  logic [W-1:0]     a, b, v, d, x, y, g, q_ab;
  logic [CNT_W-1:0] cnt, cnt_a, cnt_b, cnt_fin;
  logic             entry, pend, inval;
  logic [2*W-1:0]   prod;

  logic [W-1:0]     out_g;
  logic [2*W-1:0]   out_m;
  logic [CNT_W-1:0] out_ca, out_cb;
  logic             out_inv;

  logic [W-1:0]     fa, fb, div_n, div_d, quo, rem;
  logic             div_start, div_phase;
  div_stat_t        div_stat;

  assign fa       = s_tdata[W-1:0];
  assign fb       = s_tdata[32+W-1:32];
  assign s_tready = (state == ST_IDLE);
  assign cnt_fin  = cnt + CNT_W'(v > W'(1));

  always_comb begin
    unique case (state)
      ST_EUC: begin
        div_n = x;
        div_d = y;
      end
      ST_QUO: begin
        div_n = a;
        div_d = g;
      end
      default: begin
        div_n = v;
        div_d = d;
      end
    endcase
  end

  assign div_phase = (state == ST_CNTA) || (state == ST_CNTB) ||
                     (state == ST_EUC) || (state == ST_QUO);
  assign div_start = div_phase && !pend;

  gcdlcm_div #(.W(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_n),
    .divisor   (div_d),
    .quotient  (quo),
    .remainder (rem),
    .stat      (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      if (div_start) begin
        pend <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            a <= fa;
            b <= fb;
            v <= fa;
            d <= W'(FIRST_DIVISOR);
            entry <= 1'b1;
            cnt <= '0;
            if (fa < W'(2) || fb < W'(2)) begin
              inval <= 1'b1;
              state <= ST_FIN;
            end else begin
              inval <= 1'b0;
              state <= ST_CNTA;
            end
          end
        end
        ST_CNTA, ST_CNTB: begin
          if (div_stat.done) begin
            pend <= 1'b0;
            // quotient below divisor on a fresh divisor means d*d > v
            if (entry && quo < d) begin
              if (state == ST_CNTA) begin
                cnt_a <= cnt_fin;
                v     <= b;
                d     <= W'(FIRST_DIVISOR);
                entry <= 1'b1;
                cnt   <= '0;
                state <= ST_CNTB;
              end else begin
                cnt_b <= cnt_fin;
                x     <= a;
                y     <= b;
                state <= ST_EUC;
              end
            end else if (rem == '0) begin
              v     <= quo;
              cnt   <= cnt + CNT_W'(1);
              entry <= 1'b0;
            end else begin
              d     <= d + W'(1);
              entry <= 1'b1;
            end
          end
        end
        ST_EUC: begin
          if (div_stat.done) begin
            pend <= 1'b0;
            x    <= y;
            y    <= rem;
            if (rem == '0) begin
              g     <= y;
              state <= ST_QUO;
            end
          end
        end
        ST_QUO: begin
          if (div_stat.done) begin
            pend  <= 1'b0;
            q_ab  <= quo;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= (2*W)'(q_ab) * (2*W)'(b);
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            out_inv  <= inval;
            out_g    <= inval ? '0 : g;
            out_m    <= inval ? '0 : prod;
            out_ca   <= inval ? '0 : cnt_a;
            out_cb   <= inval ? '0 : cnt_b;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {4'b0, out_cb, out_ca, OUT_M_W'(out_m), OUT_G_W'(out_g)};
  assign m_tuser = out_inv;

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tdata == '0) else $error("invalid beat not zeroed");
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> out_g != '0) else $error("zero common factor");
  a_done_pending: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> pend) else $error("divider result with no request");
`endif

endmodule
`default_nettype wire

// File: test/gcd_lcm_by_prime_factors_test.sv
// ----------------------------------------------------------------------------
// gcd_lcm_by_prime_factors_test
// Sends operand pairs into the block, works out gcd, lcm and prime factor
// counts for each pair it sends, and checks each result beat field by field.
// Small or smooth operands keep trial division short.
// ----------------------------------------------------------------------------
module gcd_lcm_by_prime_factors_test;
  import gcdlcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  NUM_RANDOM  = 85;
  localparam int  HOLD_CYCLES = 60000;
  localparam longint CYCLE_LIMIT = 20000000;

  // first_number sits in the low half of a beat
  typedef struct packed {
    logic [31:0] second_number;
    logic [31:0] first_number;
  } pair_t;

  typedef struct packed {
    logic [OUT_G_W-1:0] common_factor;
    logic [OUT_M_W-1:0] common_multiple;
    logic [CNT_W-1:0]   first_factor_count;
    logic [CNT_W-1:0]   second_factor_count;
    logic               input_invalid;
  } gcd_lcm_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;
  logic [0:0]   m_tuser;

  pair_t    pending_pairs[$];
  gcd_lcm_t expected_results[$];
  int       errors = 0;
  int       pairs_sent = 0;
  int       results_seen = 0;
  int       invalid_seen = 0;
  longint   cycles = 0;
  logic     hold_go = 1'b0;
  int       hold_left = 0;

  gcd_lcm_by_prime_factors #(.OPERAND_WIDTH(32)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [CNT_W-1:0] prime_count(longint unsigned v);
    longint unsigned n;
    longint unsigned d;
    n = 0;
    d = FIRST_DIVISOR;
    while (d * d <= v) begin
      while (v % d == 0) begin
        v = v / d;
        n++;
      end
      d++;
    end
    if (v > 1) n++;
    return n[CNT_W-1:0];
  endfunction

  function automatic gcd_lcm_t gcd_lcm_of(pair_t p);
    gcd_lcm_t r;
    longint unsigned a, b, g, d, a0;
    r = '0;
    a = p.first_number;
    b = p.second_number;
    if (a < 2 || b < 2) begin
      r.input_invalid = 1'b1;
      return r;
    end
    a0 = a;
    g = 1;
    d = FIRST_DIVISOR;
    // share out the prime factors of the first operand
    while (d * d <= a) begin
      while (a % d == 0) begin
        a = a / d;
        if (b % d == 0) begin
          b = b / d;
          g = g * d;
        end
      end
      d++;
    end
    if (a > 1 && b % a == 0) g = g * a;
    r.common_factor       = g[31:0];
    r.common_multiple     = (a0 / g) * longint'(p.second_number);
    r.first_factor_count  = prime_count(a0);
    r.second_factor_count = prime_count(p.second_number);
    return r;
  endfunction

  // idle odds per hundred, sender then receiver, by progress through the run
  function automatic int idle_pct(bit receiver);
    if (pairs_sent < 45) return receiver ? 52 : 38;
    if (pairs_sent < 90) return receiver ? 38 : 52;
    return 0;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("mismatch on beat %0d: %s got %0h want %0h", results_seen, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(gcd_lcm_of(pair_t'(s_tdata)));
        pairs_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          s_tdata  <= pending_pairs.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    gcd_lcm_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.common_factor       = m_tdata[31:0];
        got.common_multiple     = m_tdata[95:32];
        got.first_factor_count  = m_tdata[101:96];
        got.second_factor_count = m_tdata[107:102];
        got.input_invalid       = m_tuser[0];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.common_factor != want.common_factor)
            report_mismatch("common_factor", got.common_factor, want.common_factor);
          if (got.common_multiple != want.common_multiple)
            report_mismatch("common_multiple", got.common_multiple, want.common_multiple);
          if (got.first_factor_count != want.first_factor_count)
            report_mismatch("first_factor_count", got.first_factor_count,
                            want.first_factor_count);
          if (got.second_factor_count != want.second_factor_count)
            report_mismatch("second_factor_count", got.second_factor_count,
                            want.second_factor_count);
          if (got.input_invalid != want.input_invalid)
            report_mismatch("input_invalid", got.input_invalid, want.input_invalid);
        end
        results_seen++;
        if (got.input_invalid) invalid_seen++;
      end
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // smooth operand: small base shifted up, so factoring stays short
  function automatic logic [31:0] smooth_operand();
    logic [31:0] base;
    int r;
    r = $urandom_range(99);
    if (r < 4) return $urandom_range(1);
    base = (r < 12) ? $urandom_range(65535, 2) : $urandom_range(4095, 2);
    return base << $urandom_range(31 - $clog2(base + 1));
  endfunction

  task automatic push_pair(logic [31:0] a, logic [31:0] b);
    pair_t p;
    p.first_number  = a;
    p.second_number = b;
    pending_pairs.push_back(p);
  endtask

  initial begin
    logic [31:0] a, b;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // directed: invalid operands, extremes, shared and coprime cases
    push_pair(32'd0, 32'd5);
    push_pair(32'd7, 32'd0);
    push_pair(32'd1, 32'd1);
    push_pair(32'd0, 32'd0);
    push_pair(32'd1, 32'hFFFFFFFF);
    push_pair(32'd2, 32'd2);
    push_pair(32'd2, 32'd3);
    push_pair(32'hFFFFFFFF, 32'hFFFFFFFF);
    push_pair(32'hFFFFFFFF, 32'd2);
    push_pair(32'h80000000, 32'hFFFF0000);
    push_pair(32'h80000000, 32'hFFFFFFFF);
    push_pair(32'd12, 32'd18);
    push_pair(32'd65521, 32'd131042);
    push_pair(32'd97, 32'd89);
    push_pair(32'd1024, 32'd48);
    push_pair(32'd65537, 32'hFFFFFFFF);
    push_pair(32'd360, 32'd360);
    // sender pause until the block has drained
    wait (pending_pairs.size() == 0 && !s_tvalid && expected_results.size() == 0);
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      a = smooth_operand();
      b = smooth_operand();
      if ($urandom_range(3) == 0 && a > 1) b = a * $urandom_range(7, 1);
      push_pair(a, b);
    end
    wait (pending_pairs.size() == 0 && !s_tvalid && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("sent %0d operand pairs, checked %0d results, %0d flagged invalid",
             pairs_sent, results_seen, invalid_seen);
    $display("covered invalid operands, 32-bit extremes, a long output stall and pauses");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/gcdlcm_pkg.sv
rtl/gcdlcm_div.sv
rtl/gcd_lcm_by_prime_factors.sv
test/gcd_lcm_by_prime_factors_test.sv
